// ===== rtl/cpcr_pkg.sv =====
// cpcr_pkg: shared types, constants and helpers of the circle pair collision resolver
// depends on nothing; used by every other file under rtl

package cpcr_pkg;

    localparam int POS_WIDTH    = 16;
    localparam int VEL_WIDTH    = 16;
    localparam int RADIUS_WIDTH = 12;
    localparam int NORM_FRAC    = 14;

    // sqrt and divider geometry
    localparam int SQRT_IN_W  = 34;
    localparam int ROOT_W     = 17;
    localparam int SQRT_REM_W = 21;
    localparam int DIVS_W     = 18;
    localparam int QUOT_W     = 15;

    // register map, index taken from paddr[2]
    localparam logic RADIUS_IDX = 1'b0;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 12'd64;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] first_x;
        logic signed [POS_WIDTH-1:0] first_y;
        logic signed [POS_WIDTH-1:0] second_x;
        logic signed [POS_WIDTH-1:0] second_y;
        logic signed [VEL_WIDTH-1:0] first_vx;
        logic signed [VEL_WIDTH-1:0] first_vy;
        logic signed [VEL_WIDTH-1:0] second_vx;
        logic signed [VEL_WIDTH-1:0] second_vy;
    } pair_in_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] new_first_x;
        logic signed [POS_WIDTH-1:0] new_first_y;
        logic signed [POS_WIDTH-1:0] new_second_x;
        logic signed [POS_WIDTH-1:0] new_second_y;
        logic signed [VEL_WIDTH-1:0] new_first_vx;
        logic signed [VEL_WIDTH-1:0] new_first_vy;
        logic signed [VEL_WIDTH-1:0] new_second_vx;
        logic signed [VEL_WIDTH-1:0] new_second_vy;
        logic                        collided;
    } pair_out_t;

    // clamp a 24 bit signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [23:0] hi;
        logic signed [23:0] lo;
        hi = 24'sd32767;
        lo = -24'sd32768;
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

// ===== rtl/cpcr_sqrt_stage.sv =====
// cpcr_sqrt_stage: a few digit steps of a restoring integer square root, registered
// depends on cpcr_pkg

module cpcr_sqrt_stage #(
    parameter int FIRST = 16,
    parameter int STEPS = 4
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [cpcr_pkg::SQRT_IN_W-1:0]      x,
    input  logic [cpcr_pkg::SQRT_REM_W-1:0]     rem_in,
    input  logic [cpcr_pkg::ROOT_W-1:0]         root_in,
    output logic [cpcr_pkg::SQRT_REM_W-1:0]     rem_reg,
    output logic [cpcr_pkg::ROOT_W-1:0]         root_reg
);

    logic [cpcr_pkg::SQRT_REM_W-1:0] rem_next;
    logic [cpcr_pkg::ROOT_W-1:0]     root_next;
    logic [cpcr_pkg::SQRT_REM_W-1:0] trial;
    logic [cpcr_pkg::SQRT_REM_W-1:0] cand;

    always_comb begin
        rem_next  = rem_in;
        root_next = root_in;
        trial     = '0;
        cand      = '0;
        for (int i = 0; i < STEPS; i++) begin
            // bring down the next pair of radicand bits
            cand  = {rem_next[cpcr_pkg::SQRT_REM_W-3:0], x[2*(FIRST-i)+1 -: 2]};
            trial = cpcr_pkg::SQRT_REM_W'({root_next, 2'b01});
            if (cand >= trial) begin
                rem_next  = cand - trial;
                root_next = {root_next[cpcr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = cand;
                root_next = {root_next[cpcr_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ===== rtl/cpcr_div_stage.sv =====
// cpcr_div_stage: a few quotient bits of a restoring unsigned divider, registered
// depends on cpcr_pkg

module cpcr_div_stage #(
    parameter int FIRST = 14,
    parameter int STEPS = 4
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [cpcr_pkg::DIVS_W-1:0]      dvs,
    input  logic [cpcr_pkg::QUOT_W-1:0]      num_lo,
    input  logic [cpcr_pkg::DIVS_W-1:0]      rem_in,
    input  logic [cpcr_pkg::QUOT_W-1:0]      q_in,
    output logic [cpcr_pkg::DIVS_W-1:0]      rem_reg,
    output logic [cpcr_pkg::QUOT_W-1:0]      q_reg
);

    logic [cpcr_pkg::DIVS_W-1:0] rem_next;
    logic [cpcr_pkg::QUOT_W-1:0] q_next;
    logic [cpcr_pkg::DIVS_W:0]   cand;

    always_comb begin
        rem_next = rem_in;
        q_next   = q_in;
        cand     = '0;
        for (int i = 0; i < STEPS; i++) begin
            cand = {rem_next, num_lo[FIRST-i]};
            if (cand >= {1'b0, dvs}) begin
                rem_next = cpcr_pkg::DIVS_W'(cand - {1'b0, dvs});
                q_next   = {q_next[cpcr_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_next = cand[cpcr_pkg::DIVS_W-1:0];
                q_next   = {q_next[cpcr_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

// ===== rtl/circle_pair_collision_resolver_core.sv =====
// circle_pair_collision_resolver_core: top level, 16 stage collision pipeline and apb register
// depends on cpcr_pkg, cpcr_sqrt_stage, cpcr_div_stage
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (cpcr_pkg::pair_in_t)
//  m_      | out       | m_valid / m_ready  | m_data  (cpcr_pkg::pair_out_t)
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata (ball_radius)
//
// one item per cycle sustained while m_ready stays high
// the 17 digit square root takes 5 stages and the 15 bit divider 4 stages
// reset (aresetn low, synchronous) clears all stage valid bits and sets the radius to 4.0
// each stage holds only while it is full and the stage after it holds, so bubbles
// collapse and the input keeps flowing while a finished item waits at m_, until every stage is full

module circle_pair_collision_resolver_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cpcr_pkg::pair_in_t    s_data,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output cpcr_pkg::pair_out_t   m_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int NSTG      = 15;     // internal stages 0..14, output register after
    localparam int SQ_FIRST  = 2;      // stages 2..6 run the square root
    localparam int SQ_N      = 5;
    localparam int ST_DIST   = 7;      // overlap depth and divider set-up
    localparam int DV_FIRST  = 8;      // stages 8..11 run the dividers
    localparam int DV_N      = 4;
    localparam int ST_MUL1   = 12;     // signed normal
    localparam int ST_MUL2   = 13;     // push and normal speed products
    localparam int ST_MUL3   = 14;     // push rounding, normal speed sum, impulse products

    typedef logic [cpcr_pkg::DIVS_W-1:0] DIVS_W_t;

    typedef struct packed {
        cpcr_pkg::pair_in_t   item;
        logic [12:0]          mx;
        logic [12:0]          my;
        logic                 sx;
        logic                 sy;
        logic                 near;
        logic                 hit;
        logic [25:0]          d2;
        logic [16:0]          dist8;
        logic [16:0]          over8;
        logic signed [15:0]   nx;
        logic signed [15:0]   ny;
        logic signed [33:0]   pxp;
        logic signed [33:0]   pyp;
        logic signed [33:0]   dvxp;
        logic signed [33:0]   dvyp;
        logic signed [17:0]   px;
        logic signed [17:0]   py;
        logic signed [34:0]   vn;
        logic signed [50:0]   ixp;
        logic signed [50:0]   iyp;
    } side_t;

    // configuration register
    logic [cpcr_pkg::RADIUS_WIDTH-1:0] radius_reg;
    logic [cpcr_pkg::RADIUS_WIDTH-1:0] radius_next;
    logic                              cfg_wr;
    logic [12:0]                       two_r;

    // pipeline control and data
    logic                              v_reg [0:NSTG-1];
    logic                              en    [0:NSTG];
    side_t                             side_reg  [0:NSTG-1];
    side_t                             side_next [0:NSTG-1];
    logic                              m_valid_reg;
    cpcr_pkg::pair_out_t               m_data_reg;
    cpcr_pkg::pair_out_t               m_data_next;

    // arithmetic unit links
    logic [cpcr_pkg::SQRT_REM_W-1:0]   sq_rem  [0:SQ_N-1];
    logic [cpcr_pkg::ROOT_W-1:0]       sq_root [0:SQ_N-1];
    logic [cpcr_pkg::DIVS_W-1:0]       dx_rem  [0:DV_N-1];
    logic [cpcr_pkg::QUOT_W-1:0]       dx_q    [0:DV_N-1];
    logic [cpcr_pkg::DIVS_W-1:0]       dy_rem  [0:DV_N-1];
    logic [cpcr_pkg::QUOT_W-1:0]       dy_q    [0:DV_N-1];
    logic [cpcr_pkg::DIVS_W-1:0]       dx_rem0;
    logic [cpcr_pkg::DIVS_W-1:0]       dy_rem0;

    // stage 0 and 1 helpers
    logic signed [16:0]                dx;
    logic signed [16:0]                dy;
    logic [16:0]                       mag_x;
    logic [16:0]                       mag_y;
    logic [26:0]                       d2_full;
    logic [25:0]                       two_r_sq;
    // stage 12 to 14 helpers
    logic [14:0]                       nxm;
    logic [14:0]                       nym;
    logic signed [16:0]                dvx;
    logic signed [16:0]                dvy;
    logic signed [34:0]                vn_sum;
    // output stage helpers
    logic signed [23:0]                ix;
    logic signed [23:0]                iy;
    logic                              vn_le0;

    // push rounding: shift by NORM_FRAC+4+1, halves away from zero
    function automatic logic signed [17:0] round_push(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [34:0] sum;
        logic [17:0] m;
        mag = v[33] ? 34'(-v) : 34'(v);
        sum = 35'(mag) + 35'(35'd1 << 18);
        m   = 18'(sum[34:19]);
        return v[33] ? -$signed(m) : $signed(m);
    endfunction

    // impulse rounding: shift by 2*NORM_FRAC, halves away from zero
    function automatic logic signed [23:0] round_imp(input logic signed [50:0] v);
        logic [50:0] mag;
        logic [51:0] sum;
        logic [23:0] m;
        mag = v[50] ? 51'(-v) : 51'(v);
        sum = 52'(mag) + 52'(52'd1 << 27);
        m   = sum[51:28];
        return v[50] ? -$signed(m) : $signed(m);
    endfunction

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cpcr_pkg::RADIUS_IDX);
    assign prdata = (paddr[2] == cpcr_pkg::RADIUS_IDX) ?
                    32'(radius_reg) : 32'd0;

    always_comb begin
        radius_next = radius_reg;
        if (cfg_wr) begin
            radius_next = pwdata[cpcr_pkg::RADIUS_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= cpcr_pkg::RADIUS_RESET;
        end else begin
            radius_reg <= radius_next;
        end
    end

    assign two_r = {radius_reg, 1'b0};

    // ---------------------------------------------------------- flow control
    // a stage takes new data when it is empty or its content moves on
    assign en[NSTG] = !m_valid_reg || m_ready;
    generate
        for (genvar k = 0; k < NSTG; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate
    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                v_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (en[NSTG]) begin
                m_valid_reg <= v_reg[NSTG-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
        if (en[NSTG]) begin
            m_data_reg <= m_data_next;
        end
    end

    // ------------------------------------------------------ stage datapath
    always_comb begin
        // stage 0: centre difference and the cheap box test
        dx    = 17'(s_data.first_x) - 17'(s_data.second_x);
        dy    = 17'(s_data.first_y) - 17'(s_data.second_y);
        mag_x = dx[16] ? 17'(-dx) : 17'(dx);
        mag_y = dy[16] ? 17'(-dy) : 17'(dy);
        side_next[0]      = side_reg[0];
        side_next[0].item = s_data;
        side_next[0].mx   = mag_x[12:0];
        side_next[0].my   = mag_y[12:0];
        side_next[0].sx   = dx[16];
        side_next[0].sy   = dy[16];
        side_next[0].near = (mag_x < 17'(two_r)) && (mag_y < 17'(two_r));

        // stage 1: squared distance against the squared diameter
        d2_full  = 27'(side_reg[0].mx) * 27'(side_reg[0].mx) +
                   27'(side_reg[0].my) * 27'(side_reg[0].my);
        two_r_sq = 26'(two_r) * 26'(two_r);
        side_next[1]     = side_reg[0];
        side_next[1].d2  = d2_full[25:0];
        side_next[1].hit = side_reg[0].near && (d2_full < 27'(two_r_sq));

        // square root stages carry the item along
        for (int k = SQ_FIRST; k < SQ_FIRST + SQ_N; k++) begin
            side_next[k] = side_reg[k-1];
        end

        // distance in Q.4 and the overlap depth
        side_next[ST_DIST]       = side_reg[ST_DIST-1];
        side_next[ST_DIST].dist8 = sq_root[SQ_N-1];
        side_next[ST_DIST].over8 = {two_r, 4'b0000} - sq_root[SQ_N-1];

        for (int k = DV_FIRST; k < DV_FIRST + DV_N; k++) begin
            side_next[k] = side_reg[k-1];
        end

        // stage 12: signed normal
        nxm = (side_reg[ST_MUL1-1].dist8 == 17'd0) ? 15'd0 : dx_q[DV_N-1];
        nym = (side_reg[ST_MUL1-1].dist8 == 17'd0) ? 15'd0 : dy_q[DV_N-1];
        side_next[ST_MUL1]    = side_reg[ST_MUL1-1];
        side_next[ST_MUL1].nx = side_reg[ST_MUL1-1].sx ? -$signed({1'b0, nxm})
                                                        :  $signed({1'b0, nxm});
        side_next[ST_MUL1].ny = side_reg[ST_MUL1-1].sy ? -$signed({1'b0, nym})
                                                        :  $signed({1'b0, nym});
        dvx = 17'(side_reg[ST_MUL1].item.first_vx) - 17'(side_reg[ST_MUL1].item.second_vx);
        dvy = 17'(side_reg[ST_MUL1].item.first_vy) - 17'(side_reg[ST_MUL1].item.second_vy);
        // products use the registered normal of stage 12, so they land in stage 13
        side_next[ST_MUL2]      = side_reg[ST_MUL1];
        side_next[ST_MUL2].pxp  = side_reg[ST_MUL1].nx * $signed({1'b0, side_reg[ST_MUL1].over8});
        side_next[ST_MUL2].pyp  = side_reg[ST_MUL1].ny * $signed({1'b0, side_reg[ST_MUL1].over8});
        side_next[ST_MUL2].dvxp = dvx * side_reg[ST_MUL1].nx;
        side_next[ST_MUL2].dvyp = dvy * side_reg[ST_MUL1].ny;

        // stage 14: round the push, sum the normal speed, then impulse products
        vn_sum = 35'(side_reg[ST_MUL2].dvxp) + 35'(side_reg[ST_MUL2].dvyp);
        side_next[ST_MUL3]     = side_reg[ST_MUL2];
        side_next[ST_MUL3].px  = round_push(side_reg[ST_MUL2].pxp);
        side_next[ST_MUL3].py  = round_push(side_reg[ST_MUL2].pyp);
        side_next[ST_MUL3].vn  = vn_sum;
        side_next[ST_MUL3].ixp = vn_sum * side_reg[ST_MUL2].nx;
        side_next[ST_MUL3].iyp = vn_sum * side_reg[ST_MUL2].ny;

        // output: impulse rounding, corrections and clamping
        ix     = round_imp(side_reg[ST_MUL3].ixp);
        iy     = round_imp(side_reg[ST_MUL3].iyp);
        vn_le0 = side_reg[ST_MUL3].vn[34] || (side_reg[ST_MUL3].vn == 35'sd0);
        m_data_next.new_first_x  = side_reg[ST_MUL3].item.first_x;
        m_data_next.new_first_y  = side_reg[ST_MUL3].item.first_y;
        m_data_next.new_second_x = side_reg[ST_MUL3].item.second_x;
        m_data_next.new_second_y = side_reg[ST_MUL3].item.second_y;
        m_data_next.new_first_vx  = side_reg[ST_MUL3].item.first_vx;
        m_data_next.new_first_vy  = side_reg[ST_MUL3].item.first_vy;
        m_data_next.new_second_vx = side_reg[ST_MUL3].item.second_vx;
        m_data_next.new_second_vy = side_reg[ST_MUL3].item.second_vy;
        m_data_next.collided      = side_reg[ST_MUL3].hit;
        if (side_reg[ST_MUL3].hit) begin
            m_data_next.new_first_x  = cpcr_pkg::sat16(24'(side_reg[ST_MUL3].item.first_x)
                                                       + 24'(side_reg[ST_MUL3].px));
            m_data_next.new_first_y  = cpcr_pkg::sat16(24'(side_reg[ST_MUL3].item.first_y)
                                                       + 24'(side_reg[ST_MUL3].py));
            m_data_next.new_second_x = cpcr_pkg::sat16(24'(side_reg[ST_MUL3].item.second_x)
                                                       - 24'(side_reg[ST_MUL3].px));
            m_data_next.new_second_y = cpcr_pkg::sat16(24'(side_reg[ST_MUL3].item.second_y)
                                                       - 24'(side_reg[ST_MUL3].py));
            if (vn_le0) begin
                m_data_next.new_first_vx  = cpcr_pkg::sat16(
                    24'(side_reg[ST_MUL3].item.first_vx) - ix);
                m_data_next.new_first_vy  = cpcr_pkg::sat16(
                    24'(side_reg[ST_MUL3].item.first_vy) - iy);
                m_data_next.new_second_vx = cpcr_pkg::sat16(
                    24'(side_reg[ST_MUL3].item.second_vx) + ix);
                m_data_next.new_second_vy = cpcr_pkg::sat16(
                    24'(side_reg[ST_MUL3].item.second_vy) + iy);
            end
        end
    end

    // -------------------------------------------------------- square root
    generate
        for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
            cpcr_sqrt_stage #(
                .FIRST (16 - 4*k),
                .STEPS ((k == SQ_N-1) ? 1 : 4)
            ) u_sqrt (
                .aclk     (aclk),
                .en       (en[SQ_FIRST+k]),
                .x        ({side_reg[SQ_FIRST+k-1].d2, 8'h00}),
                .rem_in   ((k == 0) ? '0 : sq_rem[(k == 0) ? 0 : k-1]),
                .root_in  ((k == 0) ? '0 : sq_root[(k == 0) ? 0 : k-1]),
                .rem_reg  (sq_rem[k]),
                .root_reg (sq_root[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------ dividers
    // numerator |c|<<19 + dist8, divisor 2*dist8; the top bits seed the remainder
    assign dx_rem0 = {1'b0, side_reg[ST_DIST].mx, 4'b0000}
                     + DIVS_W_t'(side_reg[ST_DIST].dist8[16:15]);
    assign dy_rem0 = {1'b0, side_reg[ST_DIST].my, 4'b0000}
                     + DIVS_W_t'(side_reg[ST_DIST].dist8[16:15]);

    generate
        for (genvar k = 0; k < DV_N; k++) begin : g_div
            cpcr_div_stage #(
                .FIRST (14 - 4*k),
                .STEPS ((k == DV_N-1) ? 3 : 4)
            ) u_div_x (
                .aclk    (aclk),
                .en      (en[DV_FIRST+k]),
                .dvs     ({side_reg[DV_FIRST+k-1].dist8, 1'b0}),
                .num_lo  (side_reg[DV_FIRST+k-1].dist8[14:0]),
                .rem_in  ((k == 0) ? dx_rem0 : dx_rem[(k == 0) ? 0 : k-1]),
                .q_in    ((k == 0) ? '0 : dx_q[(k == 0) ? 0 : k-1]),
                .rem_reg (dx_rem[k]),
                .q_reg   (dx_q[k])
            );
            cpcr_div_stage #(
                .FIRST (14 - 4*k),
                .STEPS ((k == DV_N-1) ? 3 : 4)
            ) u_div_y (
                .aclk    (aclk),
                .en      (en[DV_FIRST+k]),
                .dvs     ({side_reg[DV_FIRST+k-1].dist8, 1'b0}),
                .num_lo  (side_reg[DV_FIRST+k-1].dist8[14:0]),
                .rem_in  ((k == 0) ? dy_rem0 : dy_rem[(k == 0) ? 0 : k-1]),
                .q_in    ((k == 0) ? '0 : dy_q[(k == 0) ? 0 : k-1]),
                .rem_reg (dy_rem[k]),
                .q_reg   (dy_q[k])
            );
        end
    endgenerate

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------- assertions
    // a full last stage that cannot move keeps its item
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NSTG-1] && !en[NSTG-1]) |=> v_reg[NSTG-1])
        else $error("last stage dropped an item while stalled");

    // a colliding item always carries normal components no larger than one in magnitude
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[ST_MUL1] && side_reg[ST_MUL1].hit) |->
        (side_reg[ST_MUL1].nx <= 16'sd16384 && side_reg[ST_MUL1].nx >= -16'sd16384 &&
         side_reg[ST_MUL1].ny <= 16'sd16384 && side_reg[ST_MUL1].ny >= -16'sd16384))
        else $error("unit normal out of range");

    // input is refused only when the first stage and the output register are both occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v_reg[0] && m_valid_reg))
        else $error("input refused with room in the pipeline");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result presented straight after reset");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for circle_pair_collision_resolver_core
// depends on cpcr_pkg and the core; drives circle pairs, writes the radius over apb,
// predicts each result with a bit-exact fixed-point model and compares whole results
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY    = 15;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1500;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    cpcr_pkg::pair_in_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    cpcr_pkg::pair_out_t  m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    circle_pair_collision_resolver_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock, period 8 ns
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // model copy of the radius register
    logic [cpcr_pkg::RADIUS_WIDTH-1:0] radius_now;

    cpcr_pkg::pair_in_t  pair_queue[$];     // items waiting for the driver
    cpcr_pkg::pair_out_t resolved_queue[$]; // predicted results, oldest first
    int        mismatches;
    int        results_seen;
    int        hits_seen;
    int        idle_cycles;
    bit        timed_out;
    bit        quiet_mode;        // long stretch with no idling on either side
    bit        hold_sender;       // pause stimulus until the pipe drains

    // --- prediction ---------------------------------------------------------

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // shift right with rounding half away from zero
    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (mag(v) + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    // floor square root, bit by bit
    function automatic longint floor_sqrt(longint x);
        longint root;
        longint b;
        root = 0;
        b = longint'(1) << 60;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x = x - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    // one component of the q1.14 unit normal, dist in q.4
    function automatic longint unit_normal(longint c, longint dist8);
        longint m;
        if (dist8 == 0) return 0;
        m = ((mag(c) << 19) + dist8) / (2 * dist8);
        return (c < 0) ? -m : m;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic cpcr_pkg::pair_out_t resolve_pair(cpcr_pkg::pair_in_t p,
                                                         logic [cpcr_pkg::RADIUS_WIDTH-1:0] r);
        cpcr_pkg::pair_out_t o;
        longint x1, y1, x2, y2, vx1, vy1, vx2, vy2;
        longint dx, dy, two_r, d2, dist8, over8, nx, ny, px, py, vn, ix, iy;
        bit hit;
        x1 = p.first_x;   y1 = p.first_y;
        x2 = p.second_x;  y2 = p.second_y;
        vx1 = p.first_vx; vy1 = p.first_vy;
        vx2 = p.second_vx; vy2 = p.second_vy;
        dx = x1 - x2;
        dy = y1 - y2;
        two_r = 2 * longint'(r);
        hit = 1'b0;
        if (mag(dx) < two_r && mag(dy) < two_r) begin
            d2 = dx * dx + dy * dy;
            if (d2 < two_r * two_r) begin
                dist8 = floor_sqrt(d2 << 8);
                over8 = (two_r << 4) - dist8;
                nx = unit_normal(dx, dist8);
                ny = unit_normal(dy, dist8);
                px = round_shift(nx * over8, cpcr_pkg::NORM_FRAC + 5);
                py = round_shift(ny * over8, cpcr_pkg::NORM_FRAC + 5);
                hit = 1'b1;
                x1 += px; y1 += py;
                x2 -= px; y2 -= py;
                vn = (vx1 - vx2) * nx + (vy1 - vy2) * ny;
                // approaching or resting: swap the normal velocity component
                if (vn <= 0) begin
                    ix = round_shift(vn * nx, 2 * cpcr_pkg::NORM_FRAC);
                    iy = round_shift(vn * ny, 2 * cpcr_pkg::NORM_FRAC);
                    vx1 -= ix; vy1 -= iy;
                    vx2 += ix; vy2 += iy;
                end
            end
        end
        o.new_first_x   = clamp16(x1);
        o.new_first_y   = clamp16(y1);
        o.new_second_x  = clamp16(x2);
        o.new_second_y  = clamp16(y2);
        o.new_first_vx  = clamp16(vx1);
        o.new_first_vy  = clamp16(vy1);
        o.new_second_vx = clamp16(vx2);
        o.new_second_vy = clamp16(vy2);
        o.collided      = hit;
        return o;
    endfunction

    // --- stimulus helpers ---------------------------------------------------

    function automatic void queue_pair(cpcr_pkg::pair_in_t p);
        pair_queue = {pair_queue, p};
    endfunction

    function automatic cpcr_pkg::pair_in_t make_pair(int ax, int ay, int bx, int by,
                                                     int avx, int avy, int bvx, int bvy);
        cpcr_pkg::pair_in_t p;
        p.first_x = ax[15:0];    p.first_y = ay[15:0];
        p.second_x = bx[15:0];   p.second_y = by[15:0];
        p.first_vx = avx[15:0];  p.first_vy = avy[15:0];
        p.second_vx = bvx[15:0]; p.second_vy = bvy[15:0];
        return p;
    endfunction

    // random pair; three in four are placed close enough that they may overlap with the given radius
    function automatic cpcr_pkg::pair_in_t random_pair(logic [cpcr_pkg::RADIUS_WIDTH-1:0] r);
        cpcr_pkg::pair_in_t p;
        int span;
        p = cpcr_pkg::pair_in_t'({$urandom, $urandom, $urandom, $urandom});
        span = 2 * int'(r) + 2;
        if ($urandom_range(0, 99) < 75) begin
            p.second_x = p.first_x + 16'($urandom_range(0, 2 * span) - span);
            p.second_y = p.first_y + 16'($urandom_range(0, 2 * span) - span);
            // sometimes shrink first_vx and second_vy so the impulse stays in range
            if ($urandom_range(0, 1)) begin
                p.first_vx = 16'($signed(p.first_vx) >>> 4);
                p.second_vy = 16'($signed(p.second_vy) >>> 4);
            end
        end
        return p;
    endfunction

    // checked away from the clock edge so driver updates have settled
    task automatic wait_drained();
        while (resolved_queue.size() != 0 || pair_queue.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_radius(logic [cpcr_pkg::RADIUS_WIDTH-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(cpcr_pkg::RADIUS_IDX) << 2;
        pwdata  <= 32'(r);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radius_now = r;
    endtask

    // --- driver -------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // previous item taken or none pending: decide on the next one
            if (pair_queue.size() != 0 && !hold_sender &&
                (quiet_mode || $urandom_range(0, 99) >= 22)) begin
                s_data  <= pair_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // prediction at acceptance, using the radius in force for that item
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            resolved_queue = {resolved_queue, resolve_pair(s_data, radius_now)};
    end

    // --- monitor ------------------------------------------------------------

    always @(posedge aclk) begin
        cpcr_pkg::pair_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (resolved_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", m_data);
                end else begin
                    want = resolved_queue.pop_front();
                    if (want.collided) hits_seen++;
                    if (m_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch item %0d: expected %p, got %p",
                                     results_seen, want, m_data);
                    end
                end
            end
            m_ready <= quiet_mode || ($urandom_range(0, 99) >= 22);
        end
    end

    // watchdog: cycles with no accepted item on either channel and no apb access
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge timed_out) begin
        $display("watchdog expired with %0d results outstanding", resolved_queue.size());
        $display("Some tests failed");
        $finish;
    end

    // --- test sequence ------------------------------------------------------

    initial begin
        logic [cpcr_pkg::RADIUS_WIDTH-1:0] radius_set[5];
        int k;
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        quiet_mode = 1'b0;
        hold_sender = 1'b0;
        radius_now = cpcr_pkg::RADIUS_RESET;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset radius of 4.0
        queue_pair(make_pair(0, 0, 0, 0, 256, -256, 0, 0));           // coincident
        queue_pair(make_pair(16, 0, 0, 0, -256, 0, 256, 0));         // approaching
        queue_pair(make_pair(16, 0, 0, 0, 256, 0, -256, 0));         // separating
        queue_pair(make_pair(0, 40, 0, 0, 0, 0, 0, 0));              // resting contact
        queue_pair(make_pair(128, 0, 0, 0, 0, 0, 0, 0));             // just touching
        queue_pair(make_pair(127, 0, 0, 0, 0, -100, 0, 100));        // barely over
        queue_pair(make_pair(-32768, -32768, 32767, 32767,
                             -32768, -32768, 32767, 32767));          // extremes
        queue_pair(make_pair(32767, 32767, 32760, 32760,
                             -32768, -32768, 32767, 32767));          // saturating
        queue_pair(make_pair(-32768, -32768, -32760, -32763,
                             32767, 32767, -32768, -32768));
        queue_pair(make_pair(-3, 5, 4, -6, -1, -1, 1, 1));
        queue_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 0));               // one lsb apart
        wait_drained();

        // zero radius: never overlaps, coincident pair included
        write_radius('0);
        queue_pair(make_pair(0, 0, 0, 0, 10, 20, 30, 40));
        queue_pair(make_pair(5, 5, 5, 6, 10, 20, 30, 40));
        wait_drained();

        // largest radius: huge overlaps, plus an extreme pair still too far apart to overlap
        write_radius('1);
        queue_pair(make_pair(32767, 0, -32768, 0, -32768, 0, 32767, 0));
        queue_pair(make_pair(100, -100, -100, 100, -5000, 5000, 5000, -5000));
        queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // random part under several radii
        radius_set = '{12'd64, 12'd1, 12'd4095, 12'd300, 12'd2048};
        for (int phase = 0; phase < 5; phase++) begin
            write_radius(radius_set[phase]);
            quiet_mode = (phase == 2);
            for (k = 0; k < N_RANDOM / 5; k++) begin
                queue_pair(random_pair(radius_now));
                // sender holds off until every result is back
                if (phase == 1 && k == 150) begin
                    while (pair_queue.size() != 0 || s_valid) @(negedge aclk);
                    hold_sender = 1'b1;
                    while (resolved_queue.size() != 0) @(negedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end
        quiet_mode = 1'b0;

        $display("%0d results checked, %0d of them collisions, radius swept 0 to 4095",
                 results_seen, hits_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpcr_pkg.sv
rtl/cpcr_sqrt_stage.sv
rtl/cpcr_div_stage.sv
rtl/circle_pair_collision_resolver_core.sv
tb/testbench.sv
